@@ src/ribt_pkg.sv @@
package ribt_pkg;

  // Request codes carried on the input tuser
  localparam logic [1:0] REQ_UPDATE  = 2'd0;
  localparam logic [1:0] REQ_BLINK   = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_MIN_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_MAX_INTERVAL = 2'd1;
  localparam logic [1:0] CFG_PULSE_LENGTH = 2'd2;

  localparam int unsigned CfgW  = 31;
  localparam int unsigned TimeW = 32;

  // Generator seed and shift amounts
  localparam logic [31:0] RNG_SEED = 32'h0000_A5A5;
  localparam int unsigned RngShA   = 13;
  localparam int unsigned RngShB   = 17;
  localparam int unsigned RngShC   = 5;

  localparam logic [4:0] DIV_LAST = 5'd31;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_DIV    = 5'b00100,
    S_GAP    = 5'b01000,
    S_COMMIT = 5'b10000
  } ctrl_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic decide;
    logic div_start;
    logic div_step;
    logic gap_calc;
    logic commit;
  } ribt_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic draw;
    logic div_done;
  } ribt_sts_t;

endpackage

@@ src/ribt_ctrl.sv @@
module ribt_ctrl import ribt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  ribt_sts_t sts_i,
  output ribt_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Sequence one request through decide, divide (when a value is drawn), gap and commit
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.decide = 1'b1;
        if (sts_i.draw) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          state_d = S_GAP;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_GAP;
        end
      end
      S_GAP: begin
        cmd_o.gap_calc = 1'b1;
        state_d        = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the result until the receiver takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ src/ribt_datapath.sv @@
module ribt_datapath import ribt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [CfgW-1:0]  cfg_data_i,
  input  logic [1:0]       req_type_i,
  input  logic [TimeW-1:0] now_ms_i,
  input  ribt_cmd_t        cmd_i,
  output ribt_sts_t        sts_o,
  output logic             blinking_o,
  output logic [TimeW-1:0] next_due_o
);

  // Configuration registers
  logic [CfgW-1:0] min_q, max_q, len_q;

  // Timer state
  logic             active_q, active_d;
  logic [TimeW-1:0] start_q, start_d;
  logic [TimeW-1:0] due_q, due_d;
  logic [31:0]      rng_q, rng_d;

  // Latched request
  logic [1:0]       req_q;
  logic [TimeW-1:0] now_q;

  // Decision flags
  logic need_gap_q, draw_q;
  logic need_gap_c, draw_c, expired_c, span_nz;

  // Serial remainder unit
  logic [31:0]      dvd_q, rem_q, dsr_q;
  logic [4:0]       cnt_q;
  logic [32:0]      trial;
  logic [32:0]      trial_sub;
  logic [TimeW-1:0] gap_q;

  // Other datapath signals
  logic [CfgW-1:0]  len_eff;
  logic [TimeW-1:0] pulse_end;
  logic [CfgW-1:0]  span;
  logic [31:0]      rng_step;

  // Take configuration writes; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '0;
      max_q <= '0;
      len_q <= CfgW'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MIN_INTERVAL: min_q <= cfg_data_i;
        CFG_MAX_INTERVAL: max_q <= cfg_data_i;
        CFG_PULSE_LENGTH: len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Latch the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_type_i;
      now_q <= now_ms_i;
    end
  end

  // Pulse expiry and the need for a new gap
  assign len_eff    = (len_q == '0) ? CfgW'(1) : len_q;
  assign pulse_end  = start_q + {1'b0, len_eff};
  assign expired_c  = (now_q >= pulse_end);
  assign span_nz    = (max_q > min_q);
  assign span       = max_q - min_q;
  assign need_gap_c = ((req_q == REQ_UPDATE) && active_q && expired_c) ||
                      (req_q == REQ_RESTART);
  assign draw_c     = need_gap_c && span_nz;

  assign sts_o.draw     = draw_c;
  assign sts_o.div_done = (cnt_q == DIV_LAST);

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      need_gap_q <= need_gap_c;
      draw_q     <= draw_c;
    end
  end

  // Advance the xorshift generator, reload the seed on zero
  always_comb begin
    rng_step = rng_q ^ (rng_q << RngShA);
    rng_step = rng_step ^ (rng_step >> RngShB);
    rng_step = rng_step ^ (rng_step << RngShC);
    rng_d    = (rng_step == '0) ? RNG_SEED : rng_step;
  end

  // Restoring remainder, one dividend bit per cycle
  assign trial     = {rem_q, dvd_q[31]};
  assign trial_sub = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvd_q <= rng_d;
      rem_q <= '0;
      dsr_q <= {1'b0, span} + 32'd1;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[30:0], 1'b0};
      rem_q <= trial_sub[32] ? trial[31:0] : trial_sub[31:0];
      cnt_q <= cnt_q + 5'd1;
    end
  end

  // Form the gap: min plus the remainder when a value was drawn
  always_ff @(posedge clk_i) begin
    if (cmd_i.gap_calc) begin
      gap_q <= {1'b0, min_q} + (draw_q ? rem_q : 32'd0);
    end
  end

  // Apply the request to the timer state
  always_comb begin
    active_d = active_q;
    start_d  = start_q;
    due_d    = due_q;
    case (req_q)
      REQ_UPDATE: begin
        if (active_q) begin
          if (need_gap_q) begin
            active_d = 1'b0;
            due_d    = now_q + gap_q;
          end
        end else if (now_q >= due_q) begin
          active_d = 1'b1;
          start_d  = now_q;
        end
      end
      REQ_BLINK: begin
        due_d = now_q;
      end
      REQ_RESTART: begin
        active_d = 1'b0;
        start_d  = '0;
        due_d    = now_q + gap_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      start_q  <= '0;
      due_q    <= '0;
      rng_q    <= RNG_SEED;
    end else begin
      if (cmd_i.commit) begin
        active_q <= active_d;
        start_q  <= start_d;
        due_q    <= due_d;
      end
      if (cmd_i.div_start) begin
        rng_q <= rng_d;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      blinking_o <= active_d;
      next_due_o <= due_d;
    end
  end

endmodule

@@ src/random_interval_blink_timer.sv @@
// Random interval blink timer.
// Input stream: s_axis_tuser carries the request (update, blink now, restart),
// s_axis_tdata the current time in ms. Output stream: one result per request,
// m_axis_tdata carries the blinking flag and the next due time.
// Configuration: cfg_valid_i/cfg_index_i/cfg_data_i write min interval (0),
// max interval (1) and pulse length (2); cfg_ready_o is always high and
// writes to index 3 are dropped. Write only while the block is idle.
// A request that draws no random value passes through decide, gap and commit;
// one that draws a gap also runs the bit-serial remainder unit, which forms one
// 32-bit modulo one dividend bit at a time.
// One request is in work at a time, so the next request is taken only after
// the previous one has committed.
// The result sits in an output register: a stalled receiver holds the result
// while the next request is still accepted and worked on; that request waits
// in its last step until the register frees.
// Reset clears the timer state, seeds the generator with 0xA5A5, sets the
// pulse length to 1 and the intervals to 0.
module random_interval_blink_timer import ribt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [30:0] cfg_data_i,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] now_ms
  input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // [0] blinking, [32:1] next_due, [39:33] zero
);

  ribt_cmd_t  cmd;
  ribt_sts_t  sts;
  logic       blinking;
  logic [31:0] next_due;

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {7'd0, next_due, blinking};

  ribt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ribt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_type_i  (s_axis_tuser),
    .now_ms_i    (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .blinking_o  (blinking),
    .next_due_o  (next_due)
  );

endmodule
